// ===== rtl/core/rgbmf_pkg.sv =====
`default_nettype none

package rgbmf_pkg;

  // Frame size limits and register defaults
  localparam int DEFAULT_MAX_WIDTH  = 1024;
  localparam int DEFAULT_MAX_HEIGHT = 1024;
  localparam int REG_RESET_VALUE    = 1024;
  localparam int REG_MIN_VALUE      = 2;

  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int CHAN_W      = 8;
  localparam int COORD_W     = 10;
  localparam int WIN_N       = 9;
  localparam int MAX_RESULTS = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  localparam int PIXEL_W = $bits(pixel_t);

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } in_beat_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  red_median;
    logic [CHAN_W-1:0]  green_median;
    logic [CHAN_W-1:0]  blue_median;
    logic [COORD_W-1:0] out_column;
    logic [COORD_W-1:0] out_row;
    logic               last_of_run;
    logic               last_of_frame;
  } out_beat_t;

  // 19 compare-exchange median network for nine values
  localparam int SORT_N = 19;
  localparam int SORT_A [SORT_N] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
  localparam int SORT_B [SORT_N] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 2, 4, 2};

  function automatic logic [CHAN_W-1:0] median9(input logic [WIN_N-1:0][CHAN_W-1:0] v);
    logic [WIN_N-1:0][CHAN_W-1:0] p;
    logic [CHAN_W-1:0]            t;
    p = v;
    for (int s = 0; s < SORT_N; s++) begin
      if (p[SORT_A[s]] > p[SORT_B[s]]) begin
        t            = p[SORT_A[s]];
        p[SORT_A[s]] = p[SORT_B[s]];
        p[SORT_B[s]] = t;
      end
    end
    return p[4];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rgbmf_ram.sv =====
`default_nettype none

module rgbmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port; read data holds without re_i
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/rgbmf_median.sv =====
`default_nettype none

module rgbmf_median (
  input  wire rgbmf_pkg::pixel_t [rgbmf_pkg::WIN_N-1:0] nbr_i,
  output rgbmf_pkg::pixel_t                             med_o
);

  logic [rgbmf_pkg::WIN_N-1:0][rgbmf_pkg::CHAN_W-1:0] red_v;
  logic [rgbmf_pkg::WIN_N-1:0][rgbmf_pkg::CHAN_W-1:0] green_v;
  logic [rgbmf_pkg::WIN_N-1:0][rgbmf_pkg::CHAN_W-1:0] blue_v;

  // split channels, then one network per channel
  always_comb begin
    for (int i = 0; i < rgbmf_pkg::WIN_N; i++) begin
      red_v[i]   = nbr_i[i].red;
      green_v[i] = nbr_i[i].green;
      blue_v[i]  = nbr_i[i].blue;
    end
    med_o.red   = rgbmf_pkg::median9(red_v);
    med_o.green = rgbmf_pkg::median9(green_v);
    med_o.blue  = rgbmf_pkg::median9(blue_v);
  end

endmodule

`default_nettype wire

// ===== rtl/core/rgb_median_3x3_filter.sv =====
// 3x3 median filter for an RGB pixel stream, each channel filtered alone.
// Input channel: in_valid_i / in_stall_o, one raster-order pixel per beat.
// Output channel: out_valid_o / out_stall_i, one filtered pixel per beat,
// tagged with its centre column and row, last_of_run on the final result
// caused by one input pixel and last_of_frame on the bottom-right centre.
// Edge neighbours are clamped to the nearest row or column of the frame.
// Config: write image_width / image_height with cfg_we_i while idle; each
// write saturates to 2..MAX and restarts the frame at pixel (0,0).
// Path: a beat that completes a window passes the line store read stage and
// the window register; its results then go through the output register.
// Throughput: one pixel per cycle inside a row while the output does not
// stall. The last pixel of a row below the top completes two centres and the
// pixels of the bottom row complete up to four, one result leaving per cycle,
// so the input stalls there. Line stores are single-port-write RAMs read at accept.
// Output stall backs up through the window stage to in_stall_o; a beat
// in the output register holds. Reset clears the counters and the pipeline,
// sets both registers to 1024 (or MAX); the line stores are not cleared.
`default_nettype none

module rgb_median_3x3_filter #(
  parameter int MAX_WIDTH  = rgbmf_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgbmf_pkg::DEFAULT_MAX_HEIGHT
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire rgbmf_pkg::in_beat_t                 in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output rgbmf_pkg::out_beat_t                     out_data_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [rgbmf_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [rgbmf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = rgbmf_pkg::PIXEL_W;
  localparam int NR = rgbmf_pkg::MAX_RESULTS;
  localparam int WIDTH_RST  = (rgbmf_pkg::REG_RESET_VALUE > MAX_WIDTH) ?
                              MAX_WIDTH : rgbmf_pkg::REG_RESET_VALUE;
  localparam int HEIGHT_RST = (rgbmf_pkg::REG_RESET_VALUE > MAX_HEIGHT) ?
                              MAX_HEIGHT : rgbmf_pkg::REG_RESET_VALUE;

  // configuration and position counters
  logic [WW-1:0] width_q, width_d;
  logic [HW-1:0] height_q, height_d;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          cfg_hit;

  // line store read stage
  logic          s1_valid_q;
  rgbmf_pkg::pixel_t s1_pix_q;
  logic [CW-1:0] s1_c_q;
  logic [RW-1:0] s1_r_q;
  logic          s1_right_q, s1_bottom_q;
  logic [PW-1:0] older_rd, newer_rd;

  // window stage
  rgbmf_pkg::pixel_t win_q [3][3];
  logic [NR-1:0] pend_q, pend_next, pend_new;
  logic [CW-1:0] g_c_q;
  logic [RW-1:0] g_r_q;
  logic          g_r1_q, g_c1_q;

  // output register
  logic                 out_valid_q;
  rgbmf_pkg::out_beat_t out_data_q;

  logic in_acc, s1_adv, gen_fire, gen_free, out_ld;
  logic right, bottom;
  logic [1:0] sel;
  logic [1:0] rsel [3];
  logic [1:0] csel [3];
  rgbmf_pkg::pixel_t [rgbmf_pkg::WIN_N-1:0] nbr;
  rgbmf_pkg::pixel_t med;
  logic [CW-1:0] res_col;
  logic [RW-1:0] res_row;

  // handshake and stage movement
  assign out_ld    = !out_valid_q || !out_stall_i;
  assign gen_fire  = (pend_q != '0) && out_ld;
  assign pend_next = pend_q & (pend_q - NR'(1));
  assign gen_free  = (pend_q == '0) || (gen_fire && (pend_next == '0));
  assign s1_adv    = s1_valid_q && gen_free;
  assign in_stall_o = s1_valid_q && !gen_free;
  assign in_acc    = in_valid_i && !in_stall_o;

  assign right  = (WW'(col_q) == width_q - WW'(1));
  assign bottom = (HW'(row_q) == height_q - HW'(1));

  // register write decode with saturation
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    cfg_hit  = 1'b0;
    if (cfg_we_i) begin
      unique case (rgbmf_pkg::cfg_reg_e'(cfg_index_i))
        rgbmf_pkg::REG_IMAGE_WIDTH: begin
          cfg_hit = 1'b1;
          if (32'(cfg_data_i) < rgbmf_pkg::REG_MIN_VALUE) begin
            width_d = WW'(rgbmf_pkg::REG_MIN_VALUE);
          end else if (32'(cfg_data_i) > MAX_WIDTH) begin
            width_d = WW'(MAX_WIDTH);
          end else begin
            width_d = WW'(cfg_data_i);
          end
        end
        rgbmf_pkg::REG_IMAGE_HEIGHT: begin
          cfg_hit = 1'b1;
          if (32'(cfg_data_i) < rgbmf_pkg::REG_MIN_VALUE) begin
            height_d = HW'(rgbmf_pkg::REG_MIN_VALUE);
          end else if (32'(cfg_data_i) > MAX_HEIGHT) begin
            height_d = HW'(MAX_HEIGHT);
          end else begin
            height_d = HW'(cfg_data_i);
          end
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // registers, raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(WIDTH_RST);
      height_q <= HW'(HEIGHT_RST);
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      if (cfg_hit) begin
        col_q <= '0;
        row_q <= '0;
      end else if (in_acc) begin
        if (right) begin
          col_q <= '0;
          row_q <= bottom ? '0 : row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

  // line stores: read at accept, write back when the item moves on
  rgbmf_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_older (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_c_q),
    .wdata_i (newer_rd),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (older_rd)
  );

  rgbmf_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_newer (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_c_q),
    .wdata_i (s1_pix_q),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (newer_rd)
  );

  // read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q    <= '{red: in_data_i.red_in, green: in_data_i.green_in,
                       blue: in_data_i.blue_in};
      s1_c_q      <= col_q;
      s1_r_q      <= row_q;
      s1_right_q  <= right;
      s1_bottom_q <= bottom;
    end
  end

  // centres completed by this pixel, in raster order
  always_comb begin
    pend_new[0] = (s1_r_q != '0) && (s1_c_q != '0);
    pend_new[1] = (s1_r_q != '0) && s1_right_q;
    pend_new[2] = s1_bottom_q && (s1_c_q != '0);
    pend_new[3] = s1_bottom_q && s1_right_q;
  end

  // window shift and pending results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (s1_adv) begin
      pend_q <= pend_new;
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= older_rd;
      win_q[1][2] <= newer_rd;
      win_q[2][2] <= s1_pix_q;
    end else if (gen_fire) begin
      pend_q <= pend_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      g_c_q  <= s1_c_q;
      g_r_q  <= s1_r_q;
      g_c1_q <= (s1_c_q == CW'(1));
      g_r1_q <= (s1_r_q == RW'(1));
    end
  end

  // pick the first pending centre and its clamped neighbours
  always_comb begin
    if (pend_q[0]) begin
      sel = 2'd0;
    end else if (pend_q[1]) begin
      sel = 2'd1;
    end else if (pend_q[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    // upper centres may clamp the top row, bottom centres repeat the last row
    if (!sel[1]) begin
      rsel[0] = g_r1_q ? 2'd1 : 2'd0;
      rsel[1] = 2'd1;
      rsel[2] = 2'd2;
      res_row = g_r_q - RW'(1);
    end else begin
      rsel[0] = 2'd1;
      rsel[1] = 2'd2;
      rsel[2] = 2'd2;
      res_row = g_r_q;
    end
    // left centres may clamp the first column, right-edge centres repeat the last
    if (!sel[0]) begin
      csel[0] = g_c1_q ? 2'd1 : 2'd0;
      csel[1] = 2'd1;
      csel[2] = 2'd2;
      res_col = g_c_q - CW'(1);
    end else begin
      csel[0] = 2'd1;
      csel[1] = 2'd2;
      csel[2] = 2'd2;
      res_col = g_c_q;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        nbr[i*3 + j] = win_q[rsel[i]][csel[j]];
      end
    end
  end

  rgbmf_median u_median (
    .nbr_i (nbr),
    .med_o (med)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (gen_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_fire) begin
      out_data_q.red_median    <= med.red;
      out_data_q.green_median  <= med.green;
      out_data_q.blue_median   <= med.blue;
      out_data_q.out_column    <= rgbmf_pkg::COORD_W'(res_col);
      out_data_q.out_row       <= rgbmf_pkg::COORD_W'(res_row);
      out_data_q.last_of_run   <= (pend_next == '0);
      out_data_q.last_of_frame <= (sel == 2'd3);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  // an item held in the read stage keeps its position
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !gen_free |=> s1_valid_q && $stable(s1_c_q) && $stable(s1_r_q))
    else $error("read stage lost its item while blocked");

  // a fired result always lands in the output register
  a_fire_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_fire |=> out_valid_q)
    else $error("fired result not in output register");

  // the frame-end centre is always the last of its run
  a_frame_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.last_of_frame |-> out_data_q.last_of_run)
    else $error("frame end without run end");

  // position stays inside the configured frame
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WW'(col_q) < width_q) && (HW'(row_q) < height_q))
    else $error("raster position outside frame");

  // the window stage never takes a new item while results remain
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |-> (pend_q == '0) || (gen_fire && (pend_next == '0)))
    else $error("window overwritten with results pending");
`endif

endmodule

`default_nettype wire

// ===== sim/rgb_median_3x3_filter_tb.sv =====
`default_nettype none

module rgb_median_3x3_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbmf_pkg::*;

  // Index outside the register list: a write there must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd2;

  // Predicts the filtered pixels and checks them in order of arrival
  class median_scoreboard;
    pixel_t      older_row [DEFAULT_MAX_WIDTH];
    pixel_t      newer_row [DEFAULT_MAX_WIDTH];
    pixel_t      win [3][3];  // [row r-2..r][column c-2..c]
    int unsigned col, row, width, height;
    out_beat_t   expected_q [$];
    int unsigned errors;

    function new();
      foreach (older_row[i]) older_row[i] = '0;
      foreach (newer_row[i]) newer_row[i] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      col    = 0;
      row    = 0;
      width  = REG_RESET_VALUE;
      height = REG_RESET_VALUE;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function int unsigned saturate(logic [CFG_DATA_W-1:0] v, int unsigned hi);
      if (v < REG_MIN_VALUE) return REG_MIN_VALUE;
      if (v > hi) return hi;
      return v;
    endfunction

    // A width or height write restarts the frame at (0,0)
    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_IMAGE_WIDTH: begin
          width = saturate(v, DEFAULT_MAX_WIDTH);
          col   = 0;
          row   = 0;
        end
        REG_IMAGE_HEIGHT: begin
          height = saturate(v, DEFAULT_MAX_HEIGHT);
          col    = 0;
          row    = 0;
        end
        default: ;
      endcase
    endfunction

    // Median by rank: the value with at most four below it and at least five at or below
    function logic [CHAN_W-1:0] mid_of_nine(logic [CHAN_W-1:0] v [WIN_N]);
      int below, upto;
      for (int i = 0; i < WIN_N; i++) begin
        below = 0;
        upto  = 0;
        for (int j = 0; j < WIN_N; j++) begin
          if (v[j] < v[i]) below++;
          if (v[j] <= v[i]) upto++;
        end
        if (below <= 4 && upto >= 5) return v[i];
      end
      return v[0];
    endfunction

    // One result from the window, rows and columns picked with edge clamping
    function out_beat_t centre(int cx, int cy, int ra, int rb, int rc,
                               int ca, int cb, int cc, bit corner);
      int            rsel [3];
      int            csel [3];
      logic [CHAN_W-1:0] r [WIN_N];
      logic [CHAN_W-1:0] g [WIN_N];
      logic [CHAN_W-1:0] b [WIN_N];
      pixel_t        p;
      out_beat_t     o;
      rsel = '{ra, rb, rc};
      csel = '{ca, cb, cc};
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p            = win[rsel[i]][csel[j]];
          r[i * 3 + j] = p.red;
          g[i * 3 + j] = p.green;
          b[i * 3 + j] = p.blue;
        end
      end
      o.red_median    = mid_of_nine(r);
      o.green_median  = mid_of_nine(g);
      o.blue_median   = mid_of_nine(b);
      o.out_column    = COORD_W'(cx);
      o.out_row       = COORD_W'(cy);
      o.last_of_run   = 1'b0;
      o.last_of_frame = corner;
      return o;
    endfunction

    // Accepted input beat: shift the window, update line stores, queue results
    function void note_pixel(in_beat_t d);
      pixel_t    px;
      bit        at_right, at_bottom;
      int        top, left;
      out_beat_t burst [$];
      out_beat_t o;
      px.red    = d.red_in;
      px.green  = d.green_in;
      px.blue   = d.blue_in;
      at_right  = (col == width - 1);
      at_bottom = (row == height - 1);
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2]      = older_row[col];
      win[1][2]      = newer_row[col];
      win[2][2]      = px;
      older_row[col] = newer_row[col];
      newer_row[col] = px;
      top  = (row == 1) ? 1 : 0;
      left = (col == 1) ? 1 : 0;
      if (row >= 1 && col >= 1) burst.push_back(centre(col - 1, row - 1, top, 1, 2, left, 1, 2, 0));
      if (row >= 1 && at_right) burst.push_back(centre(col, row - 1, top, 1, 2, 1, 2, 2, 0));
      if (at_bottom && col >= 1) burst.push_back(centre(col - 1, row, 1, 2, 2, left, 1, 2, 0));
      if (at_bottom && at_right) burst.push_back(centre(col, row, 1, 2, 2, 1, 2, 2, 1));
      foreach (burst[i]) begin
        o             = burst[i];
        o.last_of_run = (i == burst.size() - 1);
        expected_q.push_back(o);
      end
      col++;
      if (col >= width) begin
        col = 0;
        row++;
        if (row >= height) row = 0;
      end
    endfunction

    task report(string what);
      if (errors < 40) $display("mismatch: %s", what);
      errors++;
    endtask

    task compare_field(string name, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want,
                       out_beat_t at);
      if (got !== want)
        report($sformatf("%s at column %0d row %0d: got %0h, expected %0h",
                         name, at.out_column, at.out_row, got, want));
    endtask

    // Accepted output beat against the oldest expectation
    task check(out_beat_t got);
      out_beat_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result for column %0d row %0d",
                         got.out_column, got.out_row));
        return;
      end
      want = expected_q.pop_front();
      compare_field("red_median", got.red_median, want.red_median, want);
      compare_field("green_median", got.green_median, want.green_median, want);
      compare_field("blue_median", got.blue_median, want.blue_median, want);
      compare_field("out_column", got.out_column, want.out_column, want);
      compare_field("out_row", got.out_row, want.out_row, want);
      compare_field("last_of_run", got.last_of_run, want.last_of_run, want);
      compare_field("last_of_frame", got.last_of_frame, want.last_of_frame, want);
    endtask
  endclass

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_beat_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_beat_t              out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic        quiet      = 1'b0;  // no idling on either side
  logic        hold_req   = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left  = 0;

  median_scoreboard sb = new();

  rgb_median_3x3_filter i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: check accepted beats, stall at random or for one long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && !out_stall) sb.check(out_data);
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left  <= 400;
        out_stall  <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 24);
      end
    end
  end

  // Register write; the enable goes low again before the task returns
  task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, v);
    @(posedge clk);
  endtask

  // One input beat; valid stays high unless an idle gap comes before the next
  task automatic send_pixel(in_beat_t d);
    if (!quiet && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_pixel(d);
  endtask

  // Stop sending and wait until every expected result is out
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic in_beat_t random_pixel(bit narrow);
    in_beat_t d;
    if (narrow) begin
      d.red_in   = CHAN_W'($urandom_range(3) * 85);
      d.green_in = CHAN_W'($urandom_range(3) * 85);
      d.blue_in  = CHAN_W'($urandom_range(3) * 85);
    end else begin
      d = in_beat_t'($urandom);
    end
    return d;
  endfunction

  // Configure a frame size, stream the pixels, optionally pause halfway
  task automatic run_phase(logic [CFG_DATA_W-1:0] w_req, logic [CFG_DATA_W-1:0] h_req,
                           in_beat_t pixels [$], bit pause_mid);
    if ($urandom_range(1)) begin
      write_cfg(REG_IMAGE_WIDTH, w_req);
      write_cfg(REG_IMAGE_HEIGHT, h_req);
    end else begin
      write_cfg(REG_IMAGE_HEIGHT, h_req);
      write_cfg(REG_IMAGE_WIDTH, w_req);
    end
    foreach (pixels[i]) begin
      // mid-frame pause; a write to an unused index must not restart the frame
      if (pause_mid && i == pixels.size() / 2) begin
        drain();
        write_cfg(REG_SPARE, CFG_DATA_W'($urandom));
      end
      send_pixel(pixels[i]);
    end
    drain();
  endtask

  initial begin : stimulus
    in_beat_t              px_q [$];
    logic [CFG_DATA_W-1:0] w_req, h_req;
    int                    w, h, frame, count, random_sent;
    bit                    narrow;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest frame from below-range writes, two frames back to back
    px_q = '{24'h000000, 24'hFFFFFF, 24'h55AA0F, 24'hAA55F0,
             24'hFF0080, 24'h00FF7F, 24'h01FE80, 24'h807F01};
    run_phase(11'd0, 11'd1, px_q, 1'b0);

    // 3x3 frame with extreme channel values, pause in the middle
    px_q = '{24'h123456, 24'hFEDCBA, 24'h0F0F0F, 24'hF0F0F0, 24'h808080,
             24'h7F7F7F, 24'h010203, 24'hFDFEFF, 24'h3C5A96};
    run_phase(11'd3, 11'd3, px_q, 1'b1);

    // Random small frames: mostly whole frames, some cut off mid-frame
    random_sent = 0;
    while (random_sent < 48) begin
      w     = $urandom_range(2, 6);
      h     = $urandom_range(2, 4);
      w_req = (w == 2 && $urandom_range(1)) ? CFG_DATA_W'($urandom_range(1)) : CFG_DATA_W'(w);
      h_req = (h == 2 && $urandom_range(1)) ? CFG_DATA_W'($urandom_range(1)) : CFG_DATA_W'(h);
      frame = w * h;
      if ($urandom_range(3) == 0) count = $urandom_range(1, 2 * frame - 1);
      else count = frame * $urandom_range(1, 2);
      narrow = ($urandom_range(2) == 0);
      px_q.delete();
      repeat (count) px_q.push_back(random_pixel(narrow));
      run_phase(w_req, h_req, px_q, count > 1 && $urandom_range(3) == 0);
      random_sent += count;
    end

    // Whole 6x4 frame with no idling on either side
    quiet <= 1'b1;
    px_q.delete();
    repeat (24) px_q.push_back(random_pixel(1'b0));
    run_phase(11'd6, 11'd4, px_q, 1'b0);
    quiet <= 1'b0;

    // Widest frame (above-range write): a few pixels of the top row, no results
    px_q.delete();
    repeat (6) px_q.push_back(random_pixel(1'b0));
    run_phase(11'd2047, 11'd2, px_q, 1'b0);

    // Tallest frame, two columns; the receiver holds off early on
    hold_req <= 1'b1;
    px_q.delete();
    repeat (20) px_q.push_back(random_pixel(1'b0));
    run_phase(11'd2, 11'd1025, px_q, 1'b0);

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timed out with %0d results outstanding", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/rgbmf_pkg.sv
rtl/core/rgbmf_ram.sv
rtl/core/rgbmf_median.sv
rtl/core/rgb_median_3x3_filter.sv
sim/rgb_median_3x3_filter_tb.sv
